// ===== src/encoder_velocity_estimator_top_defines.svh =====
// Assertion macros used by the encoder velocity estimator controller
`ifndef ENCODER_VELOCITY_ESTIMATOR_TOP_DEFINES_SVH
`define ENCODER_VELOCITY_ESTIMATOR_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off during rst
`define EVE_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define EVE_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/eve_pkg.sv =====
// Shared constants, register codes and control structs of the velocity estimator
`timescale 1ns / 1ps

package eve_pkg;

  localparam int TIME_WIDTH      = 32;
  localparam int COUNT_WIDTH     = 32;
  localparam int CPR_WIDTH       = 16;
  localparam int VEL_WIDTH       = 25;
  localparam int FRAC_BITS       = 16;
  localparam int INT_BITS        = 8;
  localparam int SCALE_WIDTH     = 20;
  localparam int LIM_SCALE_WIDTH = 13;
  localparam int Q_WIDTH         = COUNT_WIDTH + SCALE_WIDTH;
  localparam int CMP_WIDTH       = CPR_WIDTH + TIME_WIDTH;
  localparam int DIV_WIDTH       = TIME_WIDTH;
  localparam int DIV1_STEPS      = Q_WIDTH / 2;
  localparam int DIV2_STEPS      = (INT_BITS + FRAC_BITS) / 2;
  localparam int STEP_WIDTH      = $clog2(DIV1_STEPS);
  localparam int CFG_INDEX_WIDTH = 2;
  localparam int CFG_DATA_WIDTH  = 32;

  localparam logic [SCALE_WIDTH-1:0]     US_PER_S    = SCALE_WIDTH'(1000000);
  localparam logic [LIM_SCALE_WIDTH-1:0] LIMIT_SCALE = LIM_SCALE_WIDTH'(6000);

  localparam logic [CPR_WIDTH-1:0]  CPR_RESET   = CPR_WIDTH'(1024);
  localparam logic [TIME_WIDTH-1:0] STALL_RESET = TIME_WIDTH'(50000);

  localparam logic [VEL_WIDTH-1:0] VEL_MAX = {1'b0, {(VEL_WIDTH-1){1'b1}}};
  localparam logic [VEL_WIDTH-1:0] VEL_MIN = {1'b1, {(VEL_WIDTH-1){1'b0}}};

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    CFG_COUNTS_PER_REV    = 2'd0,
    CFG_REVERSE_DIRECTION = 2'd1,
    CFG_STALL_TIMEOUT     = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic load_input;
    logic delta;
    logic mag;
    logic mul;
    logic check;
    logic div_step;
    logic sat;
    logic upd;
    logic load_result;
  } eve_cmd_t;

  typedef struct packed {
    logic reject;
    logic elapsed_zero;
    logic mag_zero;
    logic saturate;
  } eve_sts_t;

endpackage

// ===== src/encoder_velocity_estimator_top.sv =====
// Top level of the encoder velocity estimator.
// Each request (timestamp_us, raw_count) yields one result with the running position, the
// signed Q8.16 velocity in revolutions per second and a rejection flag. A request whose
// count changes plausibly and whose time since the last count change is nonzero passes the
// delta, magnitude, multiply and check states, first division, saturation check, second
// division (skipped when the velocity clips), update and done; an accepted request with no
// count change goes from check to update; a rejected one, or one with no elapsed time, from
// check to done. Each waits in done while an earlier result is stalled. The long path is set
// by one shared restoring divider retiring two quotient bits a cycle, first for the count
// scaling by counts per revolution, then for the division by elapsed time. The result sits
// in an output register, so the next request is taken while it waits. Configuration writes
// are always ready and belong in idle periods only. No clearing pass follows reset.
`timescale 1ns / 1ps

module encoder_velocity_estimator_top import eve_pkg::*; (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           sample_valid,
  output logic                           sample_stall,
  input  logic [TIME_WIDTH-1:0]          timestamp_us,
  input  logic signed [COUNT_WIDTH-1:0]  raw_count,
  output logic                           result_valid,
  input  logic                           result_stall,
  output logic signed [COUNT_WIDTH-1:0]  position_count,
  output logic signed [VEL_WIDTH-1:0]    velocity_q16,
  output logic                           sample_rejected,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [CFG_INDEX_WIDTH-1:0]     cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0]      cfg_data
);

  eve_cmd_t cmd;
  eve_sts_t sts;

  assign cfg_ready = 1'b1;

  eve_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .cmd          (cmd),
    .sts          (sts)
  );

  eve_datapath u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .cfg_valid       (cfg_valid && cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .timestamp_us    (timestamp_us),
    .raw_count       (raw_count),
    .position_count  (position_count),
    .velocity_q16    (velocity_q16),
    .sample_rejected (sample_rejected)
  );

endmodule

// ===== src/eve_datapath.sv =====
// Datapath: config registers, tracking state, plausibility check, shared divider
`timescale 1ns / 1ps

module eve_datapath import eve_pkg::*; (
  input  logic                           clk,
  input  logic                           rst,
  input  eve_cmd_t                       cmd,
  output eve_sts_t                       sts,
  input  logic                           cfg_valid,
  input  logic [CFG_INDEX_WIDTH-1:0]     cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0]      cfg_data,
  input  logic [TIME_WIDTH-1:0]          timestamp_us,
  input  logic signed [COUNT_WIDTH-1:0]  raw_count,
  output logic signed [COUNT_WIDTH-1:0]  position_count,
  output logic signed [VEL_WIDTH-1:0]    velocity_q16,
  output logic                           sample_rejected
);

  // configuration
  logic [CPR_WIDTH-1:0]   counts_per_rev;
  logic                   reverse_direction;
  logic [TIME_WIDTH-1:0]  stall_timeout_us;

  // tracking state
  logic [TIME_WIDTH-1:0]  prev_time;
  logic [COUNT_WIDTH-1:0] prev_raw;
  logic [COUNT_WIDTH-1:0] position;
  logic [VEL_WIDTH-1:0]   velocity;
  logic [TIME_WIDTH-1:0]  last_change_time;

  // per-request working registers
  logic [TIME_WIDTH-1:0]  ts_r;
  logic [COUNT_WIDTH-1:0] raw_r;
  logic [TIME_WIDTH-1:0]  dt_r;
  logic                   dt_ok_r;
  logic [COUNT_WIDTH-1:0] gap_r;
  logic [TIME_WIDTH-1:0]  elapsed_r;
  logic                   neg_r;
  logic [COUNT_WIDTH-1:0] mag_r;
  logic                   stall_r;
  logic [CMP_WIDTH-1:0]   cpr_dt_r;
  logic [CMP_WIDTH-1:0]   mag_lim_r;
  logic [Q_WIDTH-1:0]     scaled_r;
  logic                   rejected_r;
  logic                   sat_r;

  // shared divider
  logic [DIV_WIDTH-1:0]   div_rem;
  logic [Q_WIDTH-1:0]     div_dividend;
  logic [Q_WIDTH-1:0]     div_quot;
  logic [DIV_WIDTH-1:0]   div_divisor;
  logic [DIV_WIDTH-1:0]   step_rem;
  logic [Q_WIDTH-1:0]     step_dividend;
  logic [Q_WIDTH-1:0]     step_quot;
  logic [DIV_WIDTH:0]     trial;

  // combinational helpers
  logic [TIME_WIDTH-1:0]                  dt_diff;
  logic                                   dt_ok;
  logic [CPR_WIDTH+TIME_WIDTH-2:0]        cpr_dt_prod;
  logic [COUNT_WIDTH+LIM_SCALE_WIDTH-1:0] mag_lim_prod;
  logic [Q_WIDTH-1:0]                     scaled_prod;
  logic [Q_WIDTH-1:0]                     sat_bound;
  logic [INT_BITS+FRAC_BITS-1:0]          vel_mag;
  logic [VEL_WIDTH-1:0]                   vel_new;

  assign dt_diff = ts_r - prev_time;
  assign dt_ok   = (dt_diff != '0) && !dt_diff[TIME_WIDTH-1];

  assign cpr_dt_prod  = counts_per_rev * dt_r[TIME_WIDTH-2:0];
  assign mag_lim_prod = mag_r * LIMIT_SCALE;
  assign scaled_prod  = mag_r * US_PER_S;

  // |gap| >= floor(cpr*dt/6000)  <=>  cpr*dt < (|gap|+1)*6000
  assign sts.reject       = !dt_ok_r || (cpr_dt_r < mag_lim_r + CMP_WIDTH'(LIMIT_SCALE));
  assign sts.elapsed_zero = (elapsed_r == '0);
  assign sts.mag_zero     = (mag_r == '0);

  // integer part of q/elapsed reaches 256 exactly when q >= elapsed*256
  assign sat_bound    = Q_WIDTH'(elapsed_r) << INT_BITS;
  assign sts.saturate = (div_quot >= sat_bound);

  assign vel_mag = div_quot[INT_BITS+FRAC_BITS-1:0];

  always_comb begin
    if (sat_r) begin
      vel_new = neg_r ? VEL_MIN : VEL_MAX;
    end else if (neg_r) begin
      vel_new = VEL_WIDTH'(0) - VEL_WIDTH'(vel_mag);
    end else begin
      vel_new = VEL_WIDTH'(vel_mag);
    end
  end

  // two restoring steps per cycle
  always_comb begin
    step_rem      = div_rem;
    step_dividend = div_dividend;
    step_quot     = div_quot;
    trial         = '0;
    for (int i = 0; i < 2; i++) begin
      trial         = {step_rem, step_dividend[Q_WIDTH-1]};
      step_dividend = step_dividend << 1;
      if (trial >= {1'b0, div_divisor}) begin
        step_rem  = DIV_WIDTH'(trial - {1'b0, div_divisor});
        step_quot = {step_quot[Q_WIDTH-2:0], 1'b1};
      end else begin
        step_rem  = trial[DIV_WIDTH-1:0];
        step_quot = {step_quot[Q_WIDTH-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      counts_per_rev    <= CPR_RESET;
      reverse_direction <= 1'b0;
      stall_timeout_us  <= STALL_RESET;
      prev_time         <= '0;
      prev_raw          <= '0;
      position          <= '0;
      velocity          <= '0;
      last_change_time  <= '0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_reg_t'(cfg_index))
          CFG_COUNTS_PER_REV:    counts_per_rev    <= cfg_data[CPR_WIDTH-1:0];
          CFG_REVERSE_DIRECTION: reverse_direction <= cfg_data[0];
          CFG_STALL_TIMEOUT:     stall_timeout_us  <= cfg_data[TIME_WIDTH-1:0];
          default: ;
        endcase
      end
      if (cmd.delta) begin
        prev_time <= ts_r;
        if (dt_ok) begin
          prev_raw <= raw_r;
        end
      end
      if (cmd.check && !sts.reject) begin
        position <= position + gap_r;
      end
      if (cmd.upd) begin
        // no count change: velocity only drops on stall, change time stays
        if (!sts.mag_zero) begin
          velocity         <= stall_r ? '0 : vel_new;
          last_change_time <= ts_r;
        end else if (stall_r) begin
          velocity <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_input) begin
      ts_r  <= timestamp_us;
      raw_r <= raw_count;
    end
    if (cmd.delta) begin
      dt_r      <= dt_diff;
      dt_ok_r   <= dt_ok;
      gap_r     <= reverse_direction ? prev_raw - raw_r : raw_r - prev_raw;
      elapsed_r <= ts_r - last_change_time;
    end
    if (cmd.mag) begin
      neg_r   <= gap_r[COUNT_WIDTH-1];
      mag_r   <= gap_r[COUNT_WIDTH-1] ? COUNT_WIDTH'(0) - gap_r : gap_r;
      stall_r <= elapsed_r > stall_timeout_us;
    end
    if (cmd.mul) begin
      cpr_dt_r  <= CMP_WIDTH'(cpr_dt_prod);
      mag_lim_r <= CMP_WIDTH'(mag_lim_prod);
      scaled_r  <= scaled_prod;
    end
    if (cmd.check) begin
      rejected_r   <= sts.reject;
      div_rem      <= '0;
      div_dividend <= scaled_r;
      div_quot     <= '0;
      div_divisor  <= DIV_WIDTH'(counts_per_rev);
    end
    if (cmd.div_step) begin
      div_rem      <= step_rem;
      div_dividend <= step_dividend;
      div_quot     <= step_quot;
    end
    if (cmd.sat) begin
      // unless saturated, q < elapsed*256, so q >> 8 is already below the divisor
      sat_r        <= sts.saturate;
      div_rem      <= div_quot[DIV_WIDTH+INT_BITS-1:INT_BITS];
      div_dividend <= {div_quot[INT_BITS-1:0], (Q_WIDTH-INT_BITS)'(0)};
      div_quot     <= '0;
      div_divisor  <= elapsed_r;
    end
    if (cmd.load_result) begin
      position_count  <= position;
      velocity_q16    <= velocity;
      sample_rejected <= rejected_r;
    end
  end

endmodule

// ===== src/eve_ctrl.sv =====
// Controller: sequences one request through check, divisions and result register
`timescale 1ns / 1ps
`include "encoder_velocity_estimator_top_defines.svh"

module eve_ctrl import eve_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     sample_valid,
  output logic     sample_stall,
  output logic     result_valid,
  input  logic     result_stall,
  output eve_cmd_t cmd,
  input  eve_sts_t sts
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DELTA,
    S_MAG,
    S_MUL,
    S_CHECK,
    S_DIV1,
    S_SAT,
    S_DIV2,
    S_UPD,
    S_DONE
  } state_t;

  state_t                state;
  logic [STEP_WIDTH-1:0] step;
  logic                  result_busy;

  assign sample_stall = (state != S_IDLE);
  assign result_busy  = result_valid && result_stall;

  always_comb begin
    cmd             = '0;
    cmd.load_input  = (state == S_IDLE) && sample_valid;
    cmd.delta       = (state == S_DELTA);
    cmd.mag         = (state == S_MAG);
    cmd.mul         = (state == S_MUL);
    cmd.check       = (state == S_CHECK);
    cmd.div_step    = (state == S_DIV1) || (state == S_DIV2);
    cmd.sat         = (state == S_SAT);
    cmd.upd         = (state == S_UPD);
    cmd.load_result = (state == S_DONE) && !result_busy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      step         <= '0;
      result_valid <= 1'b0;
    end else begin
      if (cmd.load_result) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE:  if (sample_valid) state <= S_DELTA;
        S_DELTA: state <= S_MAG;
        S_MAG:   state <= S_MUL;
        S_MUL:   state <= S_CHECK;
        S_CHECK: begin
          if (sts.reject || sts.elapsed_zero) begin
            state <= S_DONE;
          end else if (sts.mag_zero) begin
            // nothing to divide, only the stall check remains
            state <= S_UPD;
          end else begin
            state <= S_DIV1;
            step  <= STEP_WIDTH'(DIV1_STEPS - 1);
          end
        end
        S_DIV1: begin
          if (step == '0) state <= S_SAT;
          else step <= step - 1'b1;
        end
        S_SAT: begin
          if (sts.saturate) begin
            state <= S_UPD;
          end else begin
            state <= S_DIV2;
            step  <= STEP_WIDTH'(DIV2_STEPS - 1);
          end
        end
        S_DIV2: begin
          if (step == '0) state <= S_UPD;
          else step <= step - 1'b1;
        end
        S_UPD:  state <= S_DONE;
        S_DONE: if (!result_busy) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  `EVE_ASSERT_NXT(a_rej, state == S_CHECK && sts.reject, state == S_DONE, "reject in divider")
  `EVE_ASSERT_IMP(a_result_hold, cmd.load_result, !result_busy, "result overwritten")
  `EVE_ASSERT_NXT(a_div1_ends, state == S_DIV1 && step == '0, state == S_SAT, "division overran")
  `EVE_ASSERT_NXT(a_accept, cmd.load_input, state == S_DELTA, "accepted request not started")

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the encoder velocity estimator top level
`timescale 1ns / 1ps

module tb import eve_pkg::*; ();

  typedef struct packed {
    logic signed [COUNT_WIDTH-1:0] position;
    logic signed [VEL_WIDTH-1:0]   velocity;
    logic                          rejected;
  } motion_result_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          sample_valid = 1'b0;
  logic                          sample_stall;
  logic [TIME_WIDTH-1:0]         timestamp_us = '0;
  logic signed [COUNT_WIDTH-1:0] raw_count = '0;
  logic                          result_valid;
  logic                          result_stall = 1'b0;
  logic signed [COUNT_WIDTH-1:0] position_count;
  logic signed [VEL_WIDTH-1:0]   velocity_q16;
  logic                          sample_rejected;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [CFG_INDEX_WIDTH-1:0]    cfg_index = '0;
  logic [CFG_DATA_WIDTH-1:0]     cfg_data = '0;

  // predictor copy of the registers and state
  logic [CPR_WIDTH-1:0]          cfg_cpr = CPR_RESET;
  logic                          cfg_reverse = 1'b0;
  logic [TIME_WIDTH-1:0]         cfg_stall_us = STALL_RESET;
  logic [TIME_WIDTH-1:0]         est_prev_time = '0;
  logic [COUNT_WIDTH-1:0]        est_prev_raw = '0;
  logic [COUNT_WIDTH-1:0]        est_position = '0;
  logic signed [VEL_WIDTH-1:0]   est_velocity = '0;
  logic [TIME_WIDTH-1:0]         est_last_change = '0;

  motion_result_t expected_motion[$];

  bit steady = 1'b0;
  int hold_left = 0;
  int failures = 0;
  int samples_sent = 0;
  int samples_rejected = 0;
  int position_moves = 0;
  int results_seen = 0;
  int held_input_cycles = 0;

  encoder_velocity_estimator_top dut (
    .clk             (clk),
    .rst             (rst),
    .sample_valid    (sample_valid),
    .sample_stall    (sample_stall),
    .timestamp_us    (timestamp_us),
    .raw_count       (raw_count),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .position_count  (position_count),
    .velocity_q16    (velocity_q16),
    .sample_rejected (sample_rejected),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #10_000_000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic logic signed [VEL_WIDTH-1:0] scale_velocity(
    input bit neg, input logic [63:0] mag, input logic [63:0] elapsed);
    logic [63:0] q, ip, rem, frac, v, nv;
    if (cfg_cpr == 0 || elapsed == 0) return est_velocity;
    q = mag * 64'd1000000 / {48'd0, cfg_cpr};
    ip = q / elapsed;
    rem = q % elapsed;
    if (ip >= 64'd256) return neg ? VEL_MIN : VEL_MAX;
    frac = (rem << FRAC_BITS) / elapsed;
    v = (ip << FRAC_BITS) + frac;
    if (neg) begin
      nv = -v;
      return (v > 64'd16777216) ? VEL_MIN : nv[VEL_WIDTH-1:0];
    end
    return (v > 64'd16777215) ? VEL_MAX : v[VEL_WIDTH-1:0];
  endfunction

  task automatic estimate_motion(input logic [TIME_WIDTH-1:0] ts,
                                 input logic [COUNT_WIDTH-1:0] raw);
    logic [TIME_WIDTH-1:0]  dt, elapsed;
    logic [COUNT_WIDTH-1:0] gap, mag;
    logic [63:0]            limit;
    bit                     neg;
    bit                     rejected;
    motion_result_t         res;
    dt = ts - est_prev_time;
    est_prev_time = ts;
    rejected = 1'b0;
    if (dt == 0 || dt[TIME_WIDTH-1]) begin
      rejected = 1'b1;
    end else begin
      gap = raw - est_prev_raw;
      est_prev_raw = raw;
      if (cfg_reverse) gap = -gap;
      neg = gap[COUNT_WIDTH-1];
      mag = neg ? -gap : gap;
      limit = {48'd0, cfg_cpr} * {32'd0, dt} / 64'd6000;
      if ({32'd0, mag} >= limit) begin
        rejected = 1'b1;
      end else begin
        est_position = est_position + gap;
        if (gap != 0) position_moves++;
        elapsed = ts - est_last_change;
        if (elapsed != 0) begin
          if (mag != 0) est_velocity = scale_velocity(neg, {32'd0, mag}, {32'd0, elapsed});
          if (elapsed > cfg_stall_us) est_velocity = '0;
          if (mag != 0) est_last_change = ts;
        end
      end
    end
    if (rejected) samples_rejected++;
    res.position = est_position;
    res.velocity = est_velocity;
    res.rejected = rejected;
    expected_motion.push_back(res);
  endtask

  // result checker and back-pressure counter
  always @(posedge clk) begin
    motion_result_t due;
    if (!rst) begin
      if (sample_valid && sample_stall) held_input_cycles++;
      if (result_valid && !result_stall) begin
        if (expected_motion.size() == 0) begin
          $error("unexpected result: position_count %0d velocity_q16 %0d", position_count,
                 velocity_q16);
          failures++;
        end else begin
          due = expected_motion.pop_front();
          results_seen++;
          if (position_count !== due.position) begin
            $error("position_count: expected %0d, got %0d", due.position, position_count);
            failures++;
          end
          if (velocity_q16 !== due.velocity) begin
            $error("velocity_q16: expected %0d, got %0d", due.velocity, velocity_q16);
            failures++;
          end
          if (sample_rejected !== due.rejected) begin
            $error("sample_rejected: expected %0b, got %0b", due.rejected, sample_rejected);
            failures++;
          end
        end
      end
    end
  end

  // receiver: long hold when asked, otherwise random stalls outside steady phases
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      result_stall <= 1'b1;
    end else begin
      result_stall <= !steady && ($urandom_range(99) < 28);
    end
  end

  task automatic send_sample(input logic [TIME_WIDTH-1:0] ts,
                             input logic [COUNT_WIDTH-1:0] raw);
    @(negedge clk);
    while (!steady && $urandom_range(99) < 28) begin
      sample_valid <= 1'b0;
      @(negedge clk);
    end
    sample_valid <= 1'b1;
    timestamp_us <= ts;
    raw_count <= raw;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
    samples_sent++;
    estimate_motion(ts, raw);
  endtask

  // relative request: time step from the last sample, count step from the last raw count taken with a valid time step
  task automatic send_step(input logic [TIME_WIDTH-1:0] dt,
                           input logic [COUNT_WIDTH-1:0] delta);
    send_sample(est_prev_time + dt, est_prev_raw + delta);
  endtask

  task automatic drain_results();
    @(negedge clk);
    sample_valid <= 1'b0;
    while (expected_motion.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_WIDTH-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_COUNTS_PER_REV:    cfg_cpr = data[CPR_WIDTH-1:0];
      CFG_REVERSE_DIRECTION: cfg_reverse = data[0];
      CFG_STALL_TIMEOUT:     cfg_stall_us = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_random_item();
    int unsigned kind, dt;
    logic [63:0] lim;
    logic [31:0] span, delta;
    kind = $urandom_range(99);
    if (kind < 8) begin
      send_sample($urandom, $urandom);
    end else if (kind < 16) begin
      // time standing still or running backward
      send_sample(est_prev_time - $urandom_range(0, 3000), $urandom);
    end else begin
      case ($urandom_range(15))
        0, 1, 2, 3:      dt = $urandom_range(1, 200);
        11, 12, 13, 14:  dt = $urandom_range(20000, 120000);
        15:              dt = $urandom_range(1, 32'h7FFF_FFFF);
        default:         dt = $urandom_range(200, 20000);
      endcase
      lim = {48'd0, cfg_cpr} * {32'd0, dt} / 64'd6000;
      kind = $urandom_range(9);
      if (lim == 0 || kind == 0) begin
        delta = '0;
      end else begin
        if (kind == 1)
          delta = (lim > 64'h7FFF_FFFF) ? 32'h8000_0000 : lim[31:0] + $urandom_range(0, 3);
        else begin
          span = (lim - 1 > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : lim[31:0] - 1;
          delta = $urandom_range(0, span);
          if (kind < 5) delta = delta >> $urandom_range(0, 16);
        end
        if ($urandom_range(1)) delta = -delta;
      end
      send_step(dt, delta);
    end
  endtask

  task automatic run_phase(input logic [CPR_WIDTH-1:0] cpr, input bit rev,
                           input logic [TIME_WIDTH-1:0] stall_us, input int count,
                           input bit no_gaps);
    drain_results();
    write_reg(CFG_COUNTS_PER_REV, {16'd0, cpr});
    write_reg(CFG_REVERSE_DIRECTION, {31'd0, rev});
    write_reg(CFG_STALL_TIMEOUT, stall_us);
    steady = no_gaps;
    repeat (count) send_random_item();
    steady = 1'b0;
  endtask

  // reset settings: rejection rules, stall, zero elapsed, saturation, wraps
  task automatic test_directed_motion();
    send_sample('0, 32'h7FFF_FFFF);   // first sample at time zero: no time step
    send_step(6000, 100);
    send_step(6000, 0);
    send_step(60000, 0);               // no count change past the timeout
    send_step(6000, -500);
    send_step(6000, -1000);
    send_step(6000, 1024);             // right at the limit
    send_step(6000, 1023);
    send_step(0, 5);
    send_step(-1000, 5);
    send_step(1000, 10);               // lands on the last change time
    send_step(-46000, 0);
    send_step(46500, 500);             // short elapsed: clips high
    send_step(-57000, 0);
    send_step(57500, -500);            // clips low
    send_sample(32'hFFFF_F000, est_prev_raw);
    send_step(32'h1800, 5);            // timestamp wraps
    send_sample(est_prev_time + 6000, 32'h7FFF_FFF0);
    send_step(6000, 32'h20);           // raw count wraps
  endtask

  task automatic test_config_extremes();
    drain_results();
    write_reg(CFG_COUNTS_PER_REV, 32'd65535);
    write_reg(CFG_REVERSE_DIRECTION, 32'd1);
    write_reg(CFG_STALL_TIMEOUT, 32'hFFFF_FFFF);
    send_step(32'h7FFF_FFFF, 32'h8000_0000);
    send_step(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    drain_results();
    write_reg(CFG_STALL_TIMEOUT, 32'd0);
    send_step(6000, 7);
    drain_results();
    write_reg(CFG_COUNTS_PER_REV, 32'd0);
    send_step(100000, 1);
    drain_results();
    write_reg(CFG_COUNTS_PER_REV, 32'd1);
    write_reg(CFG_REVERSE_DIRECTION, 32'd0);
    send_step(60000, 9);
    send_step(60000, 10);
  endtask

  task automatic test_backpressure();
    drain_results();
    write_reg(CFG_COUNTS_PER_REV, {16'd0, CPR_RESET});
    write_reg(CFG_STALL_TIMEOUT, STALL_RESET);
    hold_left = 400;
    repeat (12) send_random_item();
    // sender waits for everything before going on
    drain_results();
    repeat (10) send_random_item();
  endtask

  task automatic test_random_phases();
    run_phase(CPR_RESET, 1'b0, STALL_RESET, 200, 1'b0);
    run_phase(16'hFFFF, 1'b1, 32'hFFFF_FFFF, 200, 1'b0);
    run_phase(16'd1, 1'b0, 32'd0, 140, 1'b0);
    run_phase(CPR_WIDTH'($urandom_range(1, 65535)), 1'($urandom_range(1)), $urandom, 200,
              1'b1);
    run_phase(16'd0, 1'b1, $urandom_range(0, 100000), 20, 1'b0);
    run_phase(CPR_WIDTH'($urandom_range(1, 65535)), 1'($urandom_range(1)),
              $urandom_range(0, 200000), 230, 1'b0);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_motion();
    test_config_extremes();
    test_backpressure();
    test_random_phases();

    @(negedge clk);
    sample_valid <= 1'b0;
    for (int n = 0; n < 20000 && expected_motion.size() != 0; n++) @(posedge clk);
    repeat (60) @(posedge clk);
    if (expected_motion.size() != 0) begin
      $error("%0d results never arrived", expected_motion.size());
      failures++;
    end

    $display("Ran %0d samples over several register settings: %0d rejected, %0d moved.",
             samples_sent, samples_rejected, position_moves);
    $display("Checked %0d results; input held off for %0d cycles.", results_seen,
             held_input_cycles);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+src
src/eve_pkg.sv
src/eve_datapath.sv
src/eve_ctrl.sv
src/encoder_velocity_estimator_top.sv
tb/tb.sv
